@@ src/length_prefixed_deframer_core_assert.svh @@
// Assertion macros for the length-prefixed deframer.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpd assertion failed");

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpd assertion failed");

`endif

@@ src/lpd_pkg.sv @@
// Shared types and constants for the length-prefixed deframer.
// No dependencies; all files but the macro header import it.
package lpd_pkg;

   localparam int DATA_W            = 8;
   localparam int LEN_W             = 32;
   localparam int LPD_LENGTH_BYTES  = 4;
   localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 32'd1048576;

   // Parser phases.
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_TYPE,
      PH_PAYLOAD,
      PH_DROP
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic [DATA_W-1:0] message_type;
      logic [DATA_W-1:0] payload_byte;
      logic              has_payload;
      logic              frame_last;
      logic              length_error;
   } rsp_item_type;

   // Result handed from the parser to the output buffer.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } parse_result_type;

endpackage

@@ src/lpd_req_if.sv @@
// Input byte channel of the deframer: valid/ready handshake with one data byte.
// Depends on lpd_pkg for the byte width.
interface lpd_req_if;
   import lpd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ src/lpd_rsp_if.sv @@
// Result channel of the deframer: valid/ready handshake with the result fields.
// Depends on lpd_pkg for the byte width.
interface lpd_rsp_if;
   import lpd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] message_type;
   logic [DATA_W-1:0] payload_byte;
   logic              has_payload;
   logic              frame_last;
   logic              length_error;

   modport source (output valid, output message_type, output payload_byte,
                   output has_payload, output frame_last, output length_error,
                   input ready);
   modport sink   (input valid, input message_type, input payload_byte,
                   input has_payload, input frame_last, input length_error,
                   output ready);
endinterface

@@ src/lpd_parser.sv @@
// Frame parser: header gathering, type capture, payload countdown, error drop.
// Depends on lpd_pkg for the phase enum and the result struct.
module lpd_parser #(
   parameter int LENGTH_BYTES = lpd_pkg::LPD_LENGTH_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_fire,
   input  logic [lpd_pkg::DATA_W-1:0]  data_byte,
   input  logic                        csr_wr_en,
   input  logic [lpd_pkg::LEN_W-1:0]   csr_wr_data,
   output lpd_pkg::parse_result_type   result
);
   import lpd_pkg::*;

   localparam int CNT_W = $clog2(LENGTH_BYTES + 1);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   header_count_ff, header_count_in;
   logic [LEN_W-1:0]   header_acc_ff, header_acc_in;
   logic               header_over_ff, header_over_in;
   logic [LEN_W-1:0]   remaining_ff, remaining_in;
   logic [DATA_W-1:0]  held_type_ff, held_type_in;
   logic [LEN_W-1:0]   max_len_ff;

   logic               last_header_byte;
   logic [LEN_W-1:0]   acc_shift;
   logic               over_next;
   logic               bad_length;
   logic               remaining_le1;

   // Header arithmetic: shift in the new byte and flag lengths beyond 32 bits.
   assign last_header_byte = (header_count_ff == CNT_W'(LENGTH_BYTES - 1));
   assign acc_shift        = {header_acc_ff[LEN_W-DATA_W-1:0], data_byte};
   assign over_next        = header_over_ff | (header_acc_ff[LEN_W-1:LEN_W-DATA_W] != '0);
   assign bad_length       = over_next | (acc_shift == '0) | (acc_shift > max_len_ff);
   assign remaining_le1    = (remaining_ff[LEN_W-1:1] == '0);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (in_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               if (last_header_byte) begin
                  phase_in = bad_length ? PH_DROP : PH_TYPE;
               end
            end
            PH_TYPE: begin
               phase_in = remaining_le1 ? PH_HEADER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (remaining_le1) begin
                  phase_in = PH_HEADER;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Datapath updates and the result of the accepted beat.
   always_comb begin
      header_count_in = header_count_ff;
      header_acc_in   = header_acc_ff;
      header_over_in  = header_over_ff;
      remaining_in    = remaining_ff;
      held_type_in    = held_type_ff;
      result          = '0;
      if (in_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               if (last_header_byte) begin
                  // Header complete: clear the gatherer for the next frame.
                  header_count_in = '0;
                  header_acc_in   = '0;
                  header_over_in  = 1'b0;
                  if (bad_length) begin
                     result.valid             = 1'b1;
                     result.item.frame_last   = 1'b1;
                     result.item.length_error = 1'b1;
                  end else begin
                     remaining_in = acc_shift;
                  end
               end else begin
                  header_count_in = header_count_ff + CNT_W'(1);
                  header_acc_in   = acc_shift;
                  header_over_in  = over_next;
               end
            end
            PH_TYPE: begin
               held_type_in = data_byte;
               if (remaining_le1) begin
                  // Frame with no payload gives one empty result.
                  remaining_in             = '0;
                  result.valid             = 1'b1;
                  result.item.message_type = data_byte;
                  result.item.frame_last   = 1'b1;
               end else begin
                  remaining_in = remaining_ff - LEN_W'(1);
               end
            end
            PH_PAYLOAD: begin
               result.valid             = 1'b1;
               result.item.message_type = held_type_ff;
               result.item.payload_byte = data_byte;
               result.item.has_payload  = 1'b1;
               result.item.frame_last   = remaining_le1;
               remaining_in = remaining_le1 ? '0 : remaining_ff - LEN_W'(1);
            end
            default: result = '0;
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         header_acc_ff   <= '0;
         header_over_ff  <= 1'b0;
         remaining_ff    <= '0;
         held_type_ff    <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_acc_ff   <= header_acc_in;
         header_over_ff  <= header_over_in;
         remaining_ff    <= remaining_in;
         held_type_ff    <= held_type_in;
      end
   end

   // Maximum frame length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

endmodule

@@ src/lpd_out_buf.sv @@
// Two-entry output buffer (result register plus skid register) for result beats.
// Depends on lpd_pkg and the assertion macro header.
`include "length_prefixed_deframer_core_assert.svh"

module lpd_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  lpd_pkg::parse_result_type  push,
   output logic                       in_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lpd_pkg::rsp_item_type      rsp_item
);
   import lpd_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         pop;

   assign pop       = main_valid_ff & rsp_ready;
   assign in_ready  = ~skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_item  = main_item_ff;

   // Fill and drain: the skid entry moves up first; new beats go to the
   // result register when it frees up, otherwise into the skid entry.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_item_in  = main_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_item_in  = push.item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = push.item;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Control bits are reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   // The skid entry is only ever occupied behind a waiting result.
   `LPD_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   // A parked beat stays parked until the consumer takes the result.
   `LPD_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_ready, skid_valid_ff)
   // No new result arrives while both entries are full.
   `LPD_ASSERT_NOW(a_no_push_when_full, clock, reset, push.valid, !skid_valid_ff)

endmodule

@@ src/length_prefixed_deframer_core.sv @@
// Top level of the length-prefixed deframer: parser plus output buffer.
// Depends on lpd_pkg, lpd_req_if, lpd_rsp_if, lpd_parser and lpd_out_buf.
//
//   channel   direction  handshake        contents
//   req_if    in         valid / ready    data_byte, one stream byte per beat
//   rsp_if    out        valid / ready    message_type, payload_byte, has_payload,
//                                         frame_last, length_error
//   csr_*     in         write enable     max_frame_length, 32 bits
//
// One byte is accepted per cycle while input is ready; each beat is parsed in the
// cycle it is taken, and any result is registered in the result or skid register.
// The two-entry output buffer keeps input ready while one result waits; input
// ready drops only when both entries hold results.
// Reset is synchronous; it returns the parser to the header phase, restores
// max_frame_length to 1048576 and empties the output buffer.
// After a bad length the block drops every input byte until reset.
module length_prefixed_deframer_core #(
   parameter int LENGTH_BYTES = lpd_pkg::LPD_LENGTH_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   lpd_req_if.sink                   req_if,
   lpd_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [lpd_pkg::LEN_W-1:0] csr_wr_data
);
   import lpd_pkg::*;

   logic             in_ready;
   logic             in_fire;
   parse_result_type parse_result;
   rsp_item_type     rsp_item;

   assign req_if.ready = in_ready;
   assign in_fire      = req_if.valid & in_ready;

   lpd_parser #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .data_byte   (req_if.data_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (parse_result)
   );

   lpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_result),
      .in_ready  (in_ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_item  (rsp_item)
   );

   // Unpack the result beat onto the channel.
   assign rsp_if.message_type = rsp_item.message_type;
   assign rsp_if.payload_byte = rsp_item.payload_byte;
   assign rsp_if.has_payload  = rsp_item.has_payload;
   assign rsp_if.frame_last   = rsp_item.frame_last;
   assign rsp_if.length_error = rsp_item.length_error;

endmodule

@@ tb/lpd_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the length-prefixed deframer. It follows the accepted byte stream,
// predicts every result beat and compares the beats that leave the block.
// Depends on lpd_pkg, lpd_req_if and lpd_rsp_if.
module lpd_checker (
   input  logic                      clock,
   input  logic                      reset,
   lpd_req_if                        req_mon,
   lpd_rsp_if                        rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [lpd_pkg::LEN_W-1:0] csr_wr_data,
   output int                        failures,
   output int                        pending
);
   import lpd_pkg::*;

   // Shadow copy of the frame parser.
   logic [LEN_W-1:0]  frame_limit;
   phase_type         parse_phase;
   int                header_bytes;
   logic [63:0]       length_acc;
   logic              length_wide;
   logic [LEN_W-1:0]  bytes_left;
   logic [DATA_W-1:0] frame_type;
   rsp_item_type      results_due[$];
   int                error_count;

   task automatic restart_header();
      parse_phase  = PH_HEADER;
      header_bytes = 0;
      length_acc   = '0;
      length_wide  = 1'b0;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Advances the shadow parser by one stream byte and queues any result it causes.
   task automatic deframe_byte(input logic [DATA_W-1:0] value);
      rsp_item_type r;
      r = '0;
      case (parse_phase)
         PH_HEADER: begin
            length_acc = (length_acc << 8) | 64'(value);
            if (length_acc > 64'hFFFF_FFFF) length_wide = 1'b1;
            length_acc = length_acc & 64'hFFFF_FFFF;
            header_bytes++;
            if (header_bytes >= LPD_LENGTH_BYTES) begin
               if (length_wide || length_acc == 0 || length_acc > 64'(frame_limit)) begin
                  // A bad length reports once, then everything is dropped.
                  parse_phase    = PH_DROP;
                  r.frame_last   = 1'b1;
                  r.length_error = 1'b1;
                  results_due.push_back(r);
               end else begin
                  bytes_left  = length_acc[LEN_W-1:0];
                  parse_phase = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            frame_type = value;
            if (bytes_left <= 1) begin
               // A frame holding only its type byte comes out as one empty beat.
               bytes_left     = '0;
               restart_header();
               r.message_type = frame_type;
               r.frame_last   = 1'b1;
               results_due.push_back(r);
            end else begin
               bytes_left--;
               parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r.message_type = frame_type;
            r.payload_byte = value;
            r.has_payload  = 1'b1;
            r.frame_last   = (bytes_left <= 1);
            results_due.push_back(r);
            if (r.frame_last) begin
               bytes_left = '0;
               restart_header();
            end else begin
               bytes_left--;
            end
         end
         default: ;
      endcase
   endtask

   // Predict on input beats, compare on result beats, track register writes.
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         frame_limit = MAX_FRAME_RESET;
         bytes_left  = '0;
         frame_type  = '0;
         error_count = 0;
         results_due.delete();
         restart_header();
      end else begin
         if (req_mon.valid && req_mon.ready) deframe_byte(req_mon.data_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (results_due.size() == 0) begin
               $error("result beat with no expected result waiting");
               error_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("message_type", int'(want.message_type),
                             int'(rsp_mon.message_type));
               compare_field("payload_byte", int'(want.payload_byte),
                             int'(rsp_mon.payload_byte));
               compare_field("has_payload", int'(want.has_payload),
                             int'(rsp_mon.has_payload));
               compare_field("frame_last", int'(want.frame_last),
                             int'(rsp_mon.frame_last));
               compare_field("length_error", int'(want.length_error),
                             int'(rsp_mon.length_error));
            end
         end
         if (csr_wr_en) frame_limit = csr_wr_data;
      end
      failures <= error_count;
      pending  <= results_due.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte stream, result back-pressure,
// register writes and the verdict. Depends on lpd_pkg, the channel interfaces,
// lpd_checker and length_prefixed_deframer_core.
module testbench;
   import lpd_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 200;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;
   int               failures;
   int               pending;
   bit               idle_on;
   bit               long_hold_wanted;
   int               bytes_sent;
   int               quiet_cycles;
   logic [LEN_W-1:0] frame_limit;

   lpd_req_if byte_ch ();
   lpd_rsp_if result_ch ();

   length_prefixed_deframer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (byte_ch),
      .rsp_if      (result_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lpd_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (byte_ch),
      .rsp_mon     (result_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one stream byte, after an optional gap, and returns at the edge that takes it.
   task automatic send_byte(input logic [DATA_W-1:0] value);
      bit taken;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         byte_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = byte_ch.ready;
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Length field, most significant byte first.
   task automatic send_header(input logic [LEN_W-1:0] len);
      logic [63:0] wide;
      wide = 64'(len);
      for (int i = LPD_LENGTH_BYTES - 1; i >= 0; i--) send_byte(wide[8*i +: 8]);
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] len);
      send_header(len);
      send_byte(DATA_W'($urandom_range(0, 255)));
      for (logic [LEN_W-1:0] n = 1; n < len; n++) send_byte(DATA_W'($urandom_range(0, 255)));
   endtask

   // Mostly short frames, some empty, some longer, some right at the limit.
   function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] limit);
      logic [LEN_W-1:0] len;
      case ($urandom_range(0, 7))
         0:       len = 1;
         1:       len = $urandom_range(17, 48);
         2:       len = (limit < 64) ? limit : 64;
         default: len = $urandom_range(2, 16);
      endcase
      if (len > limit) len = limit;
      return len;
   endfunction

   // Register writes wait until the block has drained.
   task automatic program_limit(input logic [LEN_W-1:0] value);
      byte_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      frame_limit = value;
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : result_sink
      result_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            result_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            result_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            result_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0] bad_len;
      bit               hold_issued;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      byte_ch.valid     = 1'b0;
      byte_ch.data_byte = '0;
      idle_on           = 1'b1;
      long_hold_wanted  = 1'b0;
      hold_issued       = 1'b0;
      bytes_sent        = 0;
      frame_limit       = MAX_FRAME_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset limit: empty frames with extreme types, then short payloads.
      send_header(1);
      send_byte(8'h00);
      send_header(1);
      send_byte(8'hFF);
      send_header(2);
      send_byte(8'hA5);
      send_byte(8'h00);
      send_header(3);
      send_byte(8'h5A);
      send_byte(8'hFF);
      send_byte(8'h80);

      // Smallest limit: only frames with no payload get through.
      program_limit(1);
      repeat (3) send_frame(1);

      // Largest limit; the result side holds off once so the block fills up.
      program_limit('1);
      while (bytes_sent < 500) begin
         if (bytes_sent >= 250 && !hold_issued) begin
            long_hold_wanted = 1'b1;
            hold_issued      = 1'b1;
         end
         send_frame(pick_length(frame_limit));
      end

      // Small random limit, frames up to and at it.
      program_limit($urandom_range(2, 40));
      while (bytes_sent < 900) send_frame(pick_length(frame_limit));

      // Closing stretch at full rate, then a bad length and a dropped tail.
      idle_on = 1'b0;
      while (bytes_sent < 1020) send_frame(pick_length(frame_limit));
      case ($urandom_range(0, 2))
         0:       bad_len = '0;
         1:       bad_len = frame_limit + 1;
         default: begin
            bad_len = $urandom;
            if (bad_len <= frame_limit) bad_len = frame_limit + 1;
         end
      endcase
      send_header(bad_len);
      repeat (20) send_byte(DATA_W'($urandom_range(0, 255)));
      byte_ch.valid <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
